>>> src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared sizes and command codes of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Number of slots in the pool.
  localparam int unsigned SLOTS  = 64;
  // Width of a slot number or of a list position.
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  // Width of a count that can reach SLOTS itself.
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE_SLOT = 3'd1,
    CMD_FREE_POS  = 3'd2,
    CMD_READ_POS  = 3'd3,
    CMD_FIND      = 3'd4
  } cmd_e;

endpackage

>>> src/spa_free_finder.sv
// ----------------------------------------------------------------------------
// spa_free_finder
// Finds the lowest free slot below the registered slot count.
// ----------------------------------------------------------------------------
module spa_free_finder
  import spa_pkg::*;
(
  input  logic [SLOTS-1:0]  used_i,
  input  logic [CNT_W-1:0]  limit_i,
  output logic              found_o,
  output logic [SLOT_W-1:0] index_o
);

  logic [SLOTS-1:0] avail;
  logic [SLOTS-1:0] lowest;

  always_comb begin
    for (int unsigned i = 0; i < SLOTS; i++) begin
      avail[i] = !used_i[i] && (CNT_W'(i) < limit_i);
    end
  end

  // Isolate the lowest set bit, then encode the one-hot vector.
  assign lowest  = avail & (~avail + SLOTS'(1));
  assign found_o = |avail;

  always_comb begin
    index_o = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      index_o = index_o | ({SLOT_W{lowest[i]}} & SLOT_W'(i));
    end
  end

endmodule

>>> src/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Slot pool kept as a sparse set: a slot-to-position map, a dense list of
// used slots and a used count.
// ----------------------------------------------------------------------------
// The block takes one command item on the input channel (valid/ready) and
// returns exactly one result item on the output channel (valid/ready).
// Commands allocate the lowest free slot below slot_count, free a slot by
// number or by list position, read the slot at a list position, or find the
// list position of a slot. A free moves the last list entry into the hole.
// An accepted item is decoded in the next cycle, and its result enters the
// output register at the end of that cycle unless the receiver stalls.
// No new item is accepted before the current one has executed, due to the
// read-modify-write of the position map and the slot list, both synchronous
// memories with registered read data. The output register lets a new item
// be accepted while an earlier result is still waiting; if the receiver
// stalls, the second item waits in its execute cycle until the output
// register frees up, and no further item is accepted meanwhile. Reset
// clears the used bitmap, the used count and slot_count, so every slot is
// free and no clearing pass is needed. The user writes slot_count through
// its write enable only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module slot_pool_allocator
  import spa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              slot_count_we_i,
  input  logic [CNT_W-1:0]  slot_count_i,
  // Command items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [SLOT_W-1:0] position_i,
  // Result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [SLOT_W-1:0] result_slot_o,
  output logic [SLOT_W-1:0] result_position_o,
  output logic [CNT_W-1:0]  used_count_o
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  slot_count_q;
  logic [CNT_W-1:0]  count_q;
  logic [SLOTS-1:0]  used_q;

  // Latched command and the memory read data that belongs to it.
  logic [2:0]        cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] pos_q;
  logic              found_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [SLOT_W-1:0] map_rd_q;
  logic [SLOT_W-1:0] list_pos_rd_q;
  logic [SLOT_W-1:0] list_last_rd_q;

  // Output register.
  logic              out_valid_q;
  logic              ok_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [SLOT_W-1:0] res_pos_q;
  logic [CNT_W-1:0]  res_count_q;

  // The position map holds only positions; the used bit of each slot lives
  // in used_q so that reset can mark every slot free at once. The list is
  // only ever used at positions below the count, which were all written.
  logic [SLOT_W-1:0] map_mem  [SLOTS];
  logic [SLOT_W-1:0] list_mem [SLOTS];

  logic              in_accept;
  logic              out_free;
  logic              exec_fire;
  logic [SLOT_W-1:0] last_pos;
  logic              pos_in_range;
  logic              finder_found;
  logic [SLOT_W-1:0] finder_index;

  // Execute-cycle decode results.
  logic              res_ok;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] res_pos;
  logic [CNT_W-1:0]  count_d;
  logic              map_we;
  logic [SLOT_W-1:0] map_waddr;
  logic [SLOT_W-1:0] map_wdata;
  logic              list_we;
  logic [SLOT_W-1:0] list_waddr;
  logic [SLOT_W-1:0] list_wdata;
  logic              used_set;
  logic              used_clr;
  logic [SLOT_W-1:0] used_idx;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_accept    = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign exec_fire    = (state_q == ST_EXEC) && out_free;
  assign last_pos     = SLOT_W'(count_q - CNT_W'(1));
  assign pos_in_range = {1'b0, pos_q} < count_q;

  spa_free_finder u_finder (
    .used_i  (used_q),
    .limit_i (slot_count_q),
    .found_o (finder_found),
    .index_o (finder_index)
  );

  // Decode the latched command against the data read in the accept cycle.
  // A free writes the last list entry into the hole and points the map of
  // the moved slot at it; when the freed entry is the last one, this
  // rewrites the entry onto itself and the freed slot still ends up free.
  always_comb begin
    res_ok     = 1'b0;
    res_slot   = '0;
    res_pos    = '0;
    count_d    = count_q;
    map_we     = 1'b0;
    map_waddr  = list_last_rd_q;
    map_wdata  = '0;
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = list_last_rd_q;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    used_idx   = '0;

    unique case (cmd_q)
      CMD_ALLOC: begin
        if (found_q) begin
          res_ok     = 1'b1;
          res_slot   = free_idx_q;
          res_pos    = count_q[SLOT_W-1:0];
          count_d    = count_q + CNT_W'(1);
          list_we    = 1'b1;
          list_waddr = count_q[SLOT_W-1:0];
          list_wdata = free_idx_q;
          map_we     = 1'b1;
          map_waddr  = free_idx_q;
          map_wdata  = count_q[SLOT_W-1:0];
          used_set   = 1'b1;
          used_idx   = free_idx_q;
        end
      end
      CMD_FREE_SLOT: begin
        if (used_q[slot_q]) begin
          res_ok     = 1'b1;
          res_slot   = slot_q;
          res_pos    = map_rd_q;
          count_d    = count_q - CNT_W'(1);
          list_we    = 1'b1;
          list_waddr = map_rd_q;
          map_we     = 1'b1;
          map_wdata  = map_rd_q;
          used_clr   = 1'b1;
          used_idx   = slot_q;
        end
      end
      CMD_FREE_POS: begin
        if (pos_in_range && used_q[list_pos_rd_q]) begin
          res_ok     = 1'b1;
          res_slot   = list_pos_rd_q;
          res_pos    = pos_q;
          count_d    = count_q - CNT_W'(1);
          list_we    = 1'b1;
          list_waddr = pos_q;
          map_we     = 1'b1;
          map_wdata  = pos_q;
          used_clr   = 1'b1;
          used_idx   = list_pos_rd_q;
        end
      end
      CMD_READ_POS: begin
        if (pos_in_range) begin
          res_ok   = 1'b1;
          res_slot = list_pos_rd_q;
          res_pos  = pos_q;
        end
      end
      CMD_FIND: begin
        if (used_q[slot_q]) begin
          res_ok   = 1'b1;
          res_slot = slot_q;
          res_pos  = map_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_count_q <= '0;
      count_q      <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (slot_count_we_i) begin
        slot_count_q <= slot_count_i;
      end
      // A new result may replace the one taken in the same cycle.
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state_q <= ST_IDLE;
            count_q <= count_d;
            if (used_set) begin
              used_q[used_idx] <= 1'b1;
            end else if (used_clr) begin
              used_q[used_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= command_i;
      slot_q     <= slot_i;
      pos_q      <= position_i;
      found_q    <= finder_found;
      free_idx_q <= finder_index;
    end
    if (exec_fire) begin
      ok_q        <= res_ok;
      res_slot_q  <= res_slot;
      res_pos_q   <= res_pos;
      res_count_q <= count_d;
    end
  end

  // Memories: read in the accept cycle, written back in the execute cycle.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      map_rd_q <= map_mem[slot_i];
    end
    if (exec_fire && map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      list_pos_rd_q  <= list_mem[position_i];
      list_last_rd_q <= list_mem[last_pos];
    end
    if (exec_fire && list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = ok_q;
  assign result_slot_o     = res_slot_q;
  assign result_position_o = res_pos_q;
  assign used_count_o      = res_count_q;

endmodule

>>> test/tb_slot_pool_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slot_pool_allocator
// Self-checking testbench of the slot pool allocator. A model of the sparse
// set (used bits, slot positions, dense list and count) runs alongside the
// block. Each accepted command item updates the model, which queues the
// result it expects. Every result item the block returns is checked field by
// field against the oldest queued expectation. Directed items cover the
// corner cases, then random traffic runs through several pool limits.
// ----------------------------------------------------------------------------
module tb_slot_pool_allocator;
  import spa_pkg::*;

  // Command codes that the block does not decode.
  localparam logic [2:0] CMD_UNKNOWN_MIN = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_MAX = 3'd7;

  // Cycles to let pass once all results are in, before a register write
  // and at the end of the run.
  localparam int unsigned DRAIN_CYCLES      = 4;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned LONG_STALL_CYCLES = 200;
  // Watchdog: far beyond the slowest correct run of about 560 items.
  localparam int unsigned CYCLE_LIMIT       = 200000;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] pos;
    logic [CNT_W-1:0]  count;
  } pool_result_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Block inputs, all known from time zero.
  logic              slot_count_we  = 1'b0;
  logic [CNT_W-1:0]  slot_count_val = '0;
  logic              in_valid       = 1'b0;
  logic [2:0]        command        = '0;
  logic [SLOT_W-1:0] slot           = '0;
  logic [SLOT_W-1:0] position       = '0;
  logic              out_ready      = 1'b0;

  // Block outputs.
  logic              in_ready_o;
  logic              out_valid_o;
  logic              ok_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [SLOT_W-1:0] result_position_o;
  logic [CNT_W-1:0]  used_count_o;

  // Model of the pool: used bit and list position of each slot, the dense
  // list of used slots, and its length.
  logic              slot_busy  [SLOTS];
  logic [SLOT_W-1:0] slot_pos   [SLOTS];
  logic [SLOT_W-1:0] dense_list [SLOTS];
  int unsigned       busy_count  = 0;
  int unsigned       alloc_limit = 0;

  // Results the block still owes, oldest first.
  pool_result_t pending_results[$];

  // Run control shared between the sender and the receiver.
  bit idle_on        = 1'b1;
  bit long_stall_req = 1'b0;

  // Bookkeeping for the checks and the summary.
  int unsigned fault_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned peak_busy      = 0;
  int unsigned refused_allocs = 0;
  int unsigned cycle_count    = 0;

  slot_pool_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .slot_count_we_i   (slot_count_we),
    .slot_count_i      (slot_count_val),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .command_i         (command),
    .slot_i            (slot),
    .position_i        (position),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .ok_o              (ok_o),
    .result_slot_o     (result_slot_o),
    .result_position_o (result_position_o),
    .used_count_o      (used_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Pool model
  // --------------------------------------------------------------------------

  // Takes a used slot out of the set. The last list entry fills the hole,
  // and the freed slot is left free even when it was the last entry itself.
  function automatic logic [SLOT_W-1:0] release_entry(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] hole;
    logic [SLOT_W-1:0] moved;
    hole             = slot_pos[s];
    moved            = dense_list[busy_count-1];
    dense_list[hole] = moved;
    slot_pos[moved]  = hole;
    slot_busy[s]     = 1'b0;
    slot_pos[s]      = '0;
    busy_count--;
    return hole;
  endfunction

  // Applies one command to the model and returns the result it implies.
  // A failed command reports zeros for slot and position but still the count.
  function automatic pool_result_t apply_command(logic [2:0] cmd,
                                                 logic [SLOT_W-1:0] s,
                                                 logic [SLOT_W-1:0] p);
    pool_result_t      r;
    logic [SLOT_W-1:0] victim;
    r = '0;
    case (cmd)
      CMD_ALLOC: begin
        // Lowest free slot below the limit; slots above a lowered limit
        // that are still in use do not count.
        for (int i = 0; i < alloc_limit; i++) begin
          if (!r.ok && !slot_busy[i]) begin
            r.ok                   = 1'b1;
            r.slot                 = SLOT_W'(i);
            r.pos                  = SLOT_W'(busy_count);
            dense_list[busy_count] = SLOT_W'(i);
            slot_pos[i]            = SLOT_W'(busy_count);
            slot_busy[i]           = 1'b1;
            busy_count++;
          end
        end
        if (!r.ok && alloc_limit != 0) refused_allocs++;
      end
      CMD_FREE_SLOT: begin
        if (slot_busy[s]) begin
          r.ok   = 1'b1;
          r.slot = s;
          r.pos  = release_entry(s);
        end
      end
      CMD_FREE_POS: begin
        if (p < busy_count) begin
          victim = dense_list[p];
          if (slot_busy[victim]) begin
            r.ok   = 1'b1;
            r.slot = victim;
            r.pos  = release_entry(victim);
          end
        end
      end
      CMD_READ_POS: begin
        if (p < busy_count) begin
          r.ok   = 1'b1;
          r.slot = dense_list[p];
          r.pos  = p;
        end
      end
      CMD_FIND: begin
        if (slot_busy[s]) begin
          r.ok   = 1'b1;
          r.slot = s;
          r.pos  = slot_pos[s];
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(busy_count);
    if (busy_count > peak_busy) peak_busy = busy_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one command item and returns at the edge where it was taken. The
  // expectation is queued at that edge, so the model follows the order of
  // acceptance. An idle burst, if any, comes before the item is offered.
  task automatic send_cmd(input logic [2:0] cmd, input logic [SLOT_W-1:0] s,
                          input logic [SLOT_W-1:0] p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    slot     <= s;
    position <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results = {pending_results, apply_command(cmd, s, p)};
    items_sent++;
  endtask

  // Stops offering items and waits until every owed result has come back.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the slot count while the block is idle.
  task automatic set_slot_count(input int unsigned n);
    drain_pipeline();
    slot_count_we  <= 1'b1;
    slot_count_val <= CNT_W'(n);
    @(posedge clk_i);
    slot_count_we  <= 1'b0;
    alloc_limit     = (n < SLOTS) ? n : SLOTS;
  endtask

  // One random item. Most items are commands that make sense for the
  // current pool (freeing, reading or finding slots that are in use); the
  // share of allocations steers the pool toward full or toward empty. The
  // rest is noise with every field random, unknown commands included.
  task automatic send_random_op(input int unsigned alloc_weight);
    int unsigned       roll;
    int unsigned       k;
    logic [2:0]        cmd;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] p;
    roll = $urandom_range(0, 99);
    s    = SLOT_W'($urandom_range(0, SLOTS - 1));
    p    = SLOT_W'($urandom_range(0, SLOTS - 1));
    cmd  = CMD_ALLOC;
    if (roll >= 85) begin
      cmd = 3'($urandom_range(0, 7));
    end else if (roll >= alloc_weight && busy_count != 0) begin
      k = $urandom_range(0, busy_count - 1);
      case ($urandom_range(0, 3))
        0: begin
          cmd = CMD_FREE_SLOT;
          s   = dense_list[k];
        end
        1: begin
          cmd = CMD_FREE_POS;
          p   = SLOT_W'(k);
        end
        2: begin
          cmd = CMD_READ_POS;
          p   = SLOT_W'(k);
        end
        default: begin
          cmd = CMD_FIND;
          s   = dense_list[k];
        end
      endcase
    end
    send_cmd(cmd, s, p);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // Drives ready. A long hold-off requested by a test is counted here; other
  // wise ready drops in short random bursts while idling is enabled.
  initial begin : ready_driver
    int unsigned burst;
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pool_result_t want;
    pool_result_t got;
    if (rst_ni && out_valid_o && out_ready) begin
      got = {ok_o, result_slot_o, result_position_o, used_count_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Result %0d arrived with none expected: ok=%0b slot=%0d pos=%0d used=%0d",
                   results_seen, got.ok, got.slot, got.pos, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.slot !== want.slot ||
            got.pos !== want.pos || got.count !== want.count) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("Result %0d mismatch: expected ok=%0b slot=%0d pos=%0d used=%0d",
                     results_seen, want.ok, want.slot, want.pos, want.count);
            $display("  actual ok=%0b slot=%0d pos=%0d used=%0d",
                     got.ok, got.slot, got.pos, got.count);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("slot_pool_allocator test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset the limit is zero and the pool is empty, so every
  // command fails. Unknown commands and the top field values go in here too.
  task automatic test_reset_defaults();
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_READ_POS, '0, '0);
    send_cmd(CMD_FIND, '0, '0);
    send_cmd(CMD_FREE_SLOT, SLOT_W'(SLOTS - 1), '0);
    send_cmd(CMD_FREE_POS, '0, SLOT_W'(SLOTS - 1));
    send_cmd(CMD_UNKNOWN_MIN, SLOT_W'(SLOTS - 1), SLOT_W'(SLOTS - 1));
    send_cmd(CMD_UNKNOWN_MIN + 3'd1, '0, SLOT_W'(SLOTS - 1));
    send_cmd(CMD_UNKNOWN_MAX, SLOT_W'(SLOTS - 1), '0);
  endtask

  // Every command on a small pool, including a free of the last list entry
  // (the slot must stay free) and a free that moves the last entry.
  task automatic test_basic_ops();
    set_slot_count(SLOTS);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FIND, SLOT_W'(1), '0);
    send_cmd(CMD_READ_POS, '0, SLOT_W'(2));
    send_cmd(CMD_FREE_SLOT, SLOT_W'(0), '0);
    send_cmd(CMD_FREE_POS, '0, SLOT_W'(1));
    send_cmd(CMD_FIND, SLOT_W'(1), '0);
    send_cmd(CMD_FREE_SLOT, SLOT_W'(1), '0);
    send_cmd(CMD_READ_POS, '0, SLOT_W'(1));
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_POS, '0, SLOT_W'(0));
  endtask

  // Exhaustion under a small limit, and a limit lowered below slots that are
  // still in use: they can be found and freed, but not handed out again.
  task automatic test_limit_changes();
    set_slot_count(2);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_ALLOC, '0, '0);
    set_slot_count(1);
    send_cmd(CMD_FIND, SLOT_W'(1), '0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_SLOT, SLOT_W'(1), '0);
    send_cmd(CMD_FREE_SLOT, SLOT_W'(0), '0);
    send_cmd(CMD_ALLOC, '0, '0);
    set_slot_count(0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE_SLOT, SLOT_W'(0), '0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills and stops taking items. The sender then
  // pauses until every result is back.
  task automatic test_backpressure();
    set_slot_count(SLOTS);
    idle_on        = 1'b0;
    long_stall_req = 1'b1;
    repeat (24) send_random_op(60);
    drain_pipeline();
    idle_on = 1'b1;
  endtask

  // Random traffic over several limits: steer the pool toward full, then toward
  // empty, work under a random limit, under the smallest limits, and finally run
  // without any idling.
  task automatic test_random_traffic();
    set_slot_count(SLOTS);
    repeat (90) send_random_op(60);
    repeat (90) send_random_op(10);
    set_slot_count($urandom_range(1, SLOTS - 1));
    repeat (90) send_random_op(45);
    set_slot_count(0);
    repeat (30) send_random_op(40);
    set_slot_count(1);
    repeat (30) send_random_op(40);
    set_slot_count(SLOTS);
    repeat (60) send_random_op(70);
    idle_on = 1'b0;
    repeat (120) send_random_op(40);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_pos[i]   = '0;
      dense_list[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_basic_ops();
    test_limit_changes();
    test_backpressure();
    test_random_traffic();

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d command items and %0d results; pool use peaked at %0d of %0d slots.",
             items_sent, results_seen, peak_busy, SLOTS);
    $display("Allocations refused for lack of a free slot under the limit: %0d; faults: %0d.",
             refused_allocs, fault_count);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("slot_pool_allocator test passed");
    end else begin
      $display("slot_pool_allocator test failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/spa_pkg.sv
src/spa_free_finder.sv
src/slot_pool_allocator.sv
test/tb_slot_pool_allocator.sv
